/* src/poisson_red_black_gauss_seidel_3d_core_assert.svh */
// Assertion shorthands shared by the checking code of the solver core.
`ifndef POISSON_RED_BLACK_GAUSS_SEIDEL_3D_CORE_ASSERT_SVH
`define POISSON_RED_BLACK_GAUSS_SEIDEL_3D_CORE_ASSERT_SVH

// Condition in one cycle requires a consequence in the next cycle.
`define PRBGS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("prbgs: sequenced property failed");

// Condition requires a consequence in the same cycle.
`define PRBGS_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("prbgs: property failed");

`endif

/* src/prbgs_pkg.sv */
`timescale 1ns / 1ps
package prbgs_pkg;
	localparam int MAX_GRID_X = 32;
	localparam int MAX_GRID_Y = 32;
	localparam int MAX_GRID_Z = 32;
	localparam int DEPTH  = MAX_GRID_X * MAX_GRID_Y * MAX_GRID_Z;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int NX_W   = $clog2(MAX_GRID_X + 1);
	localparam int NY_W   = $clog2(MAX_GRID_Y + 1);
	localparam int NZ_W   = $clog2(MAX_GRID_Z + 1);
	localparam int NXY_W  = $clog2(MAX_GRID_X * MAX_GRID_Y + 1);
	localparam int DATA_W = 32;
	localparam int GRID_W = 6;
	localparam int SWEEP_W = 8;
	localparam int CIDX_W = 3;
	localparam int QDEPTH = 2;
	localparam int QP_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);
	// Neighbour sum of six words, then the right-hand side taken off.
	localparam int SUM_W  = DATA_W + 3;
	localparam int DIV_W  = SUM_W + 1;
	localparam int DC_W   = $clog2(DIV_W);
	localparam int SAT_W  = 48;

	typedef enum logic [CIDX_W-1:0] {
		CFG_GRID_X      = 3'd0,
		CFG_GRID_Y      = 3'd1,
		CFG_GRID_Z      = 3'd2,
		CFG_SWEEP_COUNT = 3'd3,
		CFG_RHS_SCALE   = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_LOAD, S_READ, S_CLEAR, S_CELL, S_NB, S_NB_LAST,
		S_RHS, S_DIV, S_WRITE, S_ADV
	} state_t;

	typedef struct packed {
		action_t                  action;
		logic [AW-1:0]            cell_index;
		logic signed [DATA_W-1:0] divergence;
		logic                     load_last;
	} item_t;

	typedef struct packed {
		logic [NX_W-1:0]    nx;
		logic [NY_W-1:0]    ny;
		logic [NZ_W-1:0]    nz;
		logic [NXY_W-1:0]   nxy;
		logic [CW-1:0]      cells;
		logic [SWEEP_W-1:0] sweep_count;
		logic [DATA_W-1:0]  rhs_scale;
	} cfg_t;
endpackage

/* src/prbgs_front.sv */
`timescale 1ns / 1ps
module prbgs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [prbgs_pkg::AW-1:0]      cell_index,
	input  logic signed [prbgs_pkg::DATA_W-1:0] divergence_in,
	input  logic                          load_last,
	input  logic                          cfg_we,
	input  logic [prbgs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [prbgs_pkg::DATA_W-1:0]  cfg_data,
	output prbgs_pkg::item_t              q_item,
	output logic                          q_valid,
	input  logic                          q_pop,
	output prbgs_pkg::cfg_t               cfg
);
	logic [prbgs_pkg::GRID_W-1:0]  grid_x_q, grid_y_q, grid_z_q;
	logic [prbgs_pkg::SWEEP_W-1:0] sweep_count_q;
	logic [prbgs_pkg::DATA_W-1:0]  rhs_scale_q;
	logic [prbgs_pkg::NX_W-1:0]    nx;
	logic [prbgs_pkg::NY_W-1:0]    ny;
	logic [prbgs_pkg::NZ_W-1:0]    nz;
	logic [prbgs_pkg::NXY_W-1:0]   nxy_q;
	logic [prbgs_pkg::CW-1:0]      cells_q;
	prbgs_pkg::item_t              fifo_q [prbgs_pkg::QDEPTH];
	logic [prbgs_pkg::QP_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [prbgs_pkg::QC_W-1:0]    cnt_q;
	logic                          push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q      <= prbgs_pkg::GRID_W'(32);
			grid_y_q      <= prbgs_pkg::GRID_W'(32);
			grid_z_q      <= prbgs_pkg::GRID_W'(32);
			sweep_count_q <= prbgs_pkg::SWEEP_W'(20);
			rhs_scale_q   <= prbgs_pkg::DATA_W'(65536);
		end else if (cfg_we) begin
			unique case (prbgs_pkg::cfg_idx_t'(cfg_index))
				prbgs_pkg::CFG_GRID_X:      grid_x_q <= cfg_data[prbgs_pkg::GRID_W-1:0];
				prbgs_pkg::CFG_GRID_Y:      grid_y_q <= cfg_data[prbgs_pkg::GRID_W-1:0];
				prbgs_pkg::CFG_GRID_Z:      grid_z_q <= cfg_data[prbgs_pkg::GRID_W-1:0];
				prbgs_pkg::CFG_SWEEP_COUNT:
					sweep_count_q <= cfg_data[prbgs_pkg::SWEEP_W-1:0];
				prbgs_pkg::CFG_RHS_SCALE:   rhs_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A size of zero acts as one, a size past the maximum as the maximum.
	always_comb begin
		if (grid_x_q == '0) nx = prbgs_pkg::NX_W'(1);
		else if (32'(grid_x_q) > prbgs_pkg::MAX_GRID_X) nx = prbgs_pkg::NX_W'(prbgs_pkg::MAX_GRID_X);
		else nx = prbgs_pkg::NX_W'(grid_x_q);
		if (grid_y_q == '0) ny = prbgs_pkg::NY_W'(1);
		else if (32'(grid_y_q) > prbgs_pkg::MAX_GRID_Y) ny = prbgs_pkg::NY_W'(prbgs_pkg::MAX_GRID_Y);
		else ny = prbgs_pkg::NY_W'(grid_y_q);
		if (grid_z_q == '0) nz = prbgs_pkg::NZ_W'(1);
		else if (32'(grid_z_q) > prbgs_pkg::MAX_GRID_Z) nz = prbgs_pkg::NZ_W'(prbgs_pkg::MAX_GRID_Z);
		else nz = prbgs_pkg::NZ_W'(grid_z_q);
	end

	always_ff @(posedge clk) begin
		nxy_q   <= prbgs_pkg::NXY_W'(prbgs_pkg::NXY_W'(nx) * prbgs_pkg::NXY_W'(ny));
		cells_q <= prbgs_pkg::CW'(prbgs_pkg::CW'(nxy_q) * prbgs_pkg::CW'(nz));
	end

	assign cfg.nx          = nx;
	assign cfg.ny          = ny;
	assign cfg.nz          = nz;
	assign cfg.nxy         = nxy_q;
	assign cfg.cells       = cells_q;
	assign cfg.sweep_count = sweep_count_q;
	assign cfg.rhs_scale   = rhs_scale_q;

	assign in_ready = (cnt_q < prbgs_pkg::QC_W'(prbgs_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{action: prbgs_pkg::action_t'(action), cell_index: cell_index,
				divergence: divergence_in, load_last: load_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

/* src/prbgs_back.sv */
`timescale 1ns / 1ps
module prbgs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prbgs_pkg::item_t              q_item,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  prbgs_pkg::cfg_t               cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prbgs_pkg::AW-1:0]      read_index,
	output logic signed [prbgs_pkg::DATA_W-1:0] pressure_value,
	output logic                          clipped
);
	function automatic logic [prbgs_pkg::DATA_W:0] sat_mag(
		input logic neg, input logic [prbgs_pkg::SAT_W-1:0] mag);
		logic [prbgs_pkg::DATA_W-1:0] v;
		logic                         f;
		v = mag[prbgs_pkg::DATA_W-1:0];
		f = 1'b0;
		if (!neg) begin
			if (mag > prbgs_pkg::SAT_W'(32'h7FFF_FFFF)) begin
				v = 32'h7FFF_FFFF;
				f = 1'b1;
			end
		end else begin
			if (mag > prbgs_pkg::SAT_W'(32'h8000_0000)) begin
				v = 32'h8000_0000;
				f = 1'b1;
			end else begin
				v = -v;
			end
		end
		return {f, v};
	endfunction

	logic [prbgs_pkg::DATA_W-1:0] rhs_mem [prbgs_pkg::DEPTH];
	logic [prbgs_pkg::DATA_W-1:0] p_mem   [prbgs_pkg::DEPTH];
	logic                         rhs_we, p_we;
	logic [prbgs_pkg::AW-1:0]     rhs_waddr, rhs_raddr, p_waddr, p_raddr;
	logic [prbgs_pkg::DATA_W-1:0] rhs_wdata, p_wdata, rhs_rdata_q, p_rdata_q;

	prbgs_pkg::state_t            state_q, state_nxt;
	prbgs_pkg::item_t             item_q;
	logic                         in_range_q, load_open_q, sat_q, neg_q, parity_q, pend_q;
	logic [2*prbgs_pkg::DATA_W-1:0] prod_s1;
	logic [prbgs_pkg::CW-1:0]     clr_q;
	logic [prbgs_pkg::SWEEP_W-1:0] iter_q;
	logic [prbgs_pkg::AW-1:0]     at_q;
	logic [prbgs_pkg::NX_W-1:0]   i_q;
	logic [prbgs_pkg::NY_W-1:0]   j_q;
	logic [prbgs_pkg::NZ_W-1:0]   k_q;
	logic [2:0]                   slot_q, cnt_q, rem_q;
	logic signed [prbgs_pkg::SUM_W-1:0] sum_q;
	logic [prbgs_pkg::DIV_W-1:0]  dq_q;
	logic [prbgs_pkg::DC_W-1:0]   divcnt_q;
	logic                         out_valid_q, clipped_q;
	logic [prbgs_pkg::AW-1:0]     read_index_q;
	logic [prbgs_pkg::DATA_W-1:0] pressure_q;

	logic                         nb_ok, last_cell, out_take, cell_par, div_ge;
	logic [prbgs_pkg::AW-1:0]     nb_addr;
	logic [prbgs_pkg::DATA_W:0]   scale_res, div_res;
	logic signed [prbgs_pkg::DIV_W-1:0] v_diff;
	logic [3:0]                   div_t;
	logic [prbgs_pkg::DATA_W-1:0] div_mag32;

	always_ff @(posedge clk) begin
		if (rhs_we) rhs_mem[rhs_waddr] <= rhs_wdata;
		rhs_rdata_q <= rhs_mem[rhs_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) p_mem[p_waddr] <= p_wdata;
		p_rdata_q <= p_mem[p_raddr];
	end

	// Face neighbour for the current slot: x-, x+, y-, y+, z-, z+.
	always_comb begin
		unique case (slot_q)
			3'd0: begin
				nb_ok   = (i_q != '0);
				nb_addr = at_q - prbgs_pkg::AW'(1);
			end
			3'd1: begin
				nb_ok   = (prbgs_pkg::NX_W'(i_q + 1'b1) < cfg.nx);
				nb_addr = at_q + prbgs_pkg::AW'(1);
			end
			3'd2: begin
				nb_ok   = (j_q != '0);
				nb_addr = at_q - prbgs_pkg::AW'(cfg.nx);
			end
			3'd3: begin
				nb_ok   = (prbgs_pkg::NY_W'(j_q + 1'b1) < cfg.ny);
				nb_addr = at_q + prbgs_pkg::AW'(cfg.nx);
			end
			3'd4: begin
				nb_ok   = (k_q != '0);
				nb_addr = at_q - prbgs_pkg::AW'(cfg.nxy);
			end
			3'd5: begin
				nb_ok   = (prbgs_pkg::NZ_W'(k_q + 1'b1) < cfg.nz);
				nb_addr = at_q + prbgs_pkg::AW'(cfg.nxy);
			end
			default: begin
				nb_ok   = 1'b0;
				nb_addr = at_q;
			end
		endcase
	end

	assign last_cell = (prbgs_pkg::CW'(at_q) == cfg.cells - 1'b1);
	assign cell_par  = i_q[0] ^ j_q[0] ^ k_q[0];
	assign out_take  = !out_valid_q || out_ready;
	assign scale_res = sat_mag(neg_q, prod_s1[2*prbgs_pkg::DATA_W-1:16]);
	assign div_res   = sat_mag(neg_q, prbgs_pkg::SAT_W'(dq_q));
	assign v_diff    = prbgs_pkg::DIV_W'(sum_q) - prbgs_pkg::DIV_W'($signed(rhs_rdata_q));
	assign div_t     = {rem_q, dq_q[prbgs_pkg::DIV_W-1]};
	assign div_ge    = (div_t >= {1'b0, cnt_q});
	assign div_mag32 = item_q.divergence[prbgs_pkg::DATA_W-1] ?
		prbgs_pkg::DATA_W'(-item_q.divergence) : prbgs_pkg::DATA_W'(item_q.divergence);

	// After reset the pressure memory is cleared before the first item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= prbgs_pkg::S_CLEAR;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		rhs_we    = 1'b0;
		rhs_waddr = item_q.cell_index;
		rhs_wdata = scale_res[prbgs_pkg::DATA_W-1:0];
		rhs_raddr = at_q;
		p_we      = 1'b0;
		p_waddr   = at_q;
		p_wdata   = '0;
		p_raddr   = item_q.cell_index;
		unique case (state_q)
			prbgs_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					state_nxt = prbgs_pkg::S_DECODE;
				end
			end
			prbgs_pkg::S_DECODE: begin
				if (item_q.action == prbgs_pkg::ACT_READ) state_nxt = prbgs_pkg::S_READ;
				else state_nxt = prbgs_pkg::S_LOAD;
			end
			prbgs_pkg::S_READ: begin
				if (out_take) state_nxt = prbgs_pkg::S_IDLE;
			end
			prbgs_pkg::S_LOAD: begin
				rhs_we = in_range_q;
				if (item_q.load_last) state_nxt = prbgs_pkg::S_CLEAR;
				else state_nxt = prbgs_pkg::S_IDLE;
			end
			prbgs_pkg::S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q[prbgs_pkg::AW-1:0];
				if (clr_q == prbgs_pkg::CW'(prbgs_pkg::DEPTH - 1)) begin
					if (iter_q == '0) state_nxt = prbgs_pkg::S_IDLE;
					else state_nxt = prbgs_pkg::S_CELL;
				end
			end
			prbgs_pkg::S_CELL: begin
				if (cell_par != parity_q) state_nxt = prbgs_pkg::S_ADV;
				else state_nxt = prbgs_pkg::S_NB;
			end
			prbgs_pkg::S_NB: begin
				p_raddr = nb_addr;
				if (slot_q == 3'd5) state_nxt = prbgs_pkg::S_NB_LAST;
			end
			prbgs_pkg::S_NB_LAST: state_nxt = prbgs_pkg::S_RHS;
			prbgs_pkg::S_RHS: begin
				// A cell without neighbours is simply zeroed.
				if (cnt_q == '0) begin
					p_we      = 1'b1;
					state_nxt = prbgs_pkg::S_ADV;
				end else begin
					state_nxt = prbgs_pkg::S_DIV;
				end
			end
			prbgs_pkg::S_DIV: begin
				if (divcnt_q == prbgs_pkg::DC_W'(prbgs_pkg::DIV_W - 1)) state_nxt = prbgs_pkg::S_WRITE;
			end
			prbgs_pkg::S_WRITE: begin
				p_we      = 1'b1;
				p_wdata   = div_res[prbgs_pkg::DATA_W-1:0];
				state_nxt = prbgs_pkg::S_ADV;
			end
			prbgs_pkg::S_ADV: begin
				if (last_cell && parity_q && iter_q == prbgs_pkg::SWEEP_W'(1))
					state_nxt = prbgs_pkg::S_IDLE;
				else
					state_nxt = prbgs_pkg::S_CELL;
			end
			default: state_nxt = prbgs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_open_q <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == prbgs_pkg::S_DECODE && item_q.action == prbgs_pkg::ACT_LOAD
					&& !load_open_q) begin
				load_open_q <= 1'b1;
				sat_q       <= 1'b0;
			end
			if (state_q == prbgs_pkg::S_LOAD) begin
				if (in_range_q && scale_res[prbgs_pkg::DATA_W]) sat_q <= 1'b1;
				if (item_q.load_last) load_open_q <= 1'b0;
			end
			if (state_q == prbgs_pkg::S_WRITE && div_res[prbgs_pkg::DATA_W]) sat_q <= 1'b1;
			if (state_q == prbgs_pkg::S_READ && out_take) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			iter_q <= '0;
		end else if (state_q == prbgs_pkg::S_LOAD) begin
			clr_q  <= '0;
			iter_q <= cfg.sweep_count;
		end else if (state_q == prbgs_pkg::S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end else if (state_q == prbgs_pkg::S_ADV && last_cell && parity_q) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			prbgs_pkg::S_IDLE: begin
				if (q_valid) item_q <= q_item;
			end
			prbgs_pkg::S_DECODE: begin
				in_range_q <= (prbgs_pkg::CW'(item_q.cell_index) < cfg.cells);
				neg_q      <= item_q.divergence[prbgs_pkg::DATA_W-1];
				prod_s1    <= (2*prbgs_pkg::DATA_W)'(div_mag32) * (2*prbgs_pkg::DATA_W)'(cfg.rhs_scale);
			end
			prbgs_pkg::S_READ: begin
				if (out_take) begin
					read_index_q <= item_q.cell_index;
					pressure_q   <= in_range_q ? p_rdata_q : '0;
					clipped_q    <= sat_q;
				end
			end
			prbgs_pkg::S_LOAD: begin
				parity_q <= 1'b0;
				at_q     <= '0;
				i_q      <= '0;
				j_q      <= '0;
				k_q      <= '0;
			end
			prbgs_pkg::S_CELL: begin
				slot_q <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end
			prbgs_pkg::S_NB: begin
				if (pend_q) begin
					sum_q <= sum_q + prbgs_pkg::SUM_W'($signed(p_rdata_q));
					cnt_q <= cnt_q + 1'b1;
				end
				pend_q <= nb_ok;
				slot_q <= slot_q + 1'b1;
			end
			prbgs_pkg::S_NB_LAST: begin
				if (pend_q) begin
					sum_q <= sum_q + prbgs_pkg::SUM_W'($signed(p_rdata_q));
					cnt_q <= cnt_q + 1'b1;
				end
			end
			prbgs_pkg::S_RHS: begin
				neg_q    <= v_diff[prbgs_pkg::DIV_W-1];
				dq_q     <= v_diff[prbgs_pkg::DIV_W-1] ? prbgs_pkg::DIV_W'(-v_diff)
					: prbgs_pkg::DIV_W'(v_diff);
				rem_q    <= '0;
				divcnt_q <= '0;
			end
			prbgs_pkg::S_DIV: begin
				// One quotient bit per cycle; the divisor is the neighbour count.
				rem_q    <= div_ge ? 3'(div_t - {1'b0, cnt_q}) : div_t[2:0];
				dq_q     <= {dq_q[prbgs_pkg::DIV_W-2:0], div_ge};
				divcnt_q <= divcnt_q + 1'b1;
			end
			prbgs_pkg::S_ADV: begin
				if (last_cell) begin
					at_q     <= '0;
					i_q      <= '0;
					j_q      <= '0;
					k_q      <= '0;
					parity_q <= ~parity_q;
				end else begin
					at_q <= at_q + 1'b1;
					if (prbgs_pkg::NX_W'(i_q + 1'b1) == cfg.nx) begin
						i_q <= '0;
						if (prbgs_pkg::NY_W'(j_q + 1'b1) == cfg.ny) begin
							j_q <= '0;
							k_q <= k_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign read_index     = read_index_q;
	assign pressure_value = pressure_q;
	assign clipped        = clipped_q;
endmodule

/* src/poisson_red_black_gauss_seidel_3d_core.sv */
`timescale 1ns / 1ps
// Red-black Gauss-Seidel pressure solver over a grid of up to 32x32x32 cells in signed
// Q16.16. Inputs enter a two-item queue and are carried out one at a time by a sequencer
// around two single-port-per-direction memories (right-hand side and pressure). A load
// marked last clears the whole pressure memory and runs sweep_count iterations; each
// iteration visits every cell twice and updates a cell of the current parity with six
// neighbour reads, a right-hand-side read and a bit-serial divide by the neighbour count.
// After reset the pressure memory is cleared the same way before the first queued item
// is carried out. Configuration must be written only while no item is in progress; the
// block itself does not enforce this.
module poisson_red_black_gauss_seidel_3d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [prbgs_pkg::AW-1:0]      cell_index,
	input  logic signed [prbgs_pkg::DATA_W-1:0] divergence_in,
	input  logic                          load_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prbgs_pkg::AW-1:0]      read_index,
	output logic signed [prbgs_pkg::DATA_W-1:0] pressure_value,
	output logic                          clipped,
	input  logic                          cfg_we,
	input  logic [prbgs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [prbgs_pkg::DATA_W-1:0]  cfg_data
);
	prbgs_pkg::item_t q_item;
	prbgs_pkg::cfg_t  cfg;
	logic             q_valid, q_pop;

	prbgs_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .cell_index, .divergence_in,
		.load_last, .cfg_we, .cfg_index, .cfg_data, .q_item, .q_valid, .q_pop, .cfg
	);

	prbgs_back u_back (
		.clk, .arst_n, .q_item, .q_valid, .q_pop, .cfg, .out_valid, .out_ready,
		.read_index, .pressure_value, .clipped
	);
endmodule

/* src/prbgs_check.sv */
`timescale 1ns / 1ps
`include "poisson_red_black_gauss_seidel_3d_core_assert.svh"
module prbgs_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [prbgs_pkg::AW-1:0]     read_index,
	input logic [prbgs_pkg::DATA_W-1:0] pressure_value,
	input logic                         clipped
);
	`PRBGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PRBGS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(read_index) && $stable(pressure_value) && $stable(clipped))
	`PRBGS_ASSERT_NOW(a_rst_no_out, clk, arst_n, $past(!arst_n), !out_valid)
	`PRBGS_ASSERT_NOW(a_rst_ready, clk, arst_n, $past(!arst_n), in_ready)
endmodule

bind poisson_red_black_gauss_seidel_3d_core prbgs_check u_check (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .read_index, .pressure_value, .clipped
);

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int CELLS_MAX = prbgs_pkg::MAX_GRID_X * prbgs_pkg::MAX_GRID_Y *
		prbgs_pkg::MAX_GRID_Z;
	localparam int SESSIONS_PER_PHASE = 4;
	localparam int READS_PER_SESSION = 110;

	typedef struct {
		logic [prbgs_pkg::AW-1:0] idx;
		logic [31:0]   pressure;
		logic          clip;
	} pressure_rd_t;

	typedef struct {
		bit                  is_cfg;
		prbgs_pkg::cfg_idx_t reg_sel;
		logic [31:0]         reg_val;
		prbgs_pkg::action_t  act;
		logic [prbgs_pkg::AW-1:0] idx;
		logic [31:0]         div;
		bit                  last;
		bit                  typed;
		logic [31:0]         want_p;
		logic                want_c;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [prbgs_pkg::AW-1:0] cell_index = '0;
	logic signed [prbgs_pkg::DATA_W-1:0] divergence_in = '0;
	logic load_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [prbgs_pkg::AW-1:0] read_index;
	logic signed [prbgs_pkg::DATA_W-1:0] pressure_value;
	logic clipped;
	logic cfg_we = 1'b0;
	logic [prbgs_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [prbgs_pkg::DATA_W-1:0] cfg_data = '0;

	poisson_red_black_gauss_seidel_3d_core DUT (.*);

	always #CLK_HALF clk = ~clk;

	// Shadow of the solver state.
	logic [5:0]  sh_gx, sh_gy, sh_gz;
	logic [7:0]  sh_sweeps;
	logic [31:0] sh_scale;
	int          rhs_mem[CELLS_MAX];
	int          p_mem[CELLS_MAX];
	bit          sat_flag;
	bit          session_open;

	pressure_rd_t pending_reads[$];
	int  errors = 0;
	int  cycles = 0;
	bit  tx_idle = 0;
	int  tx_idle_pct = 87;
	bit  rx_stall = 0;
	int  rx_stall_pct = 87;
	bit  hold_req = 0;
	int  hold_left = 0;
	dir_row_t dir_tab[$];

	function automatic int axis(logic [5:0] v, int top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	function automatic int saturate(longint v);
		if (v > 64'sd2147483647) begin
			sat_flag = 1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat_flag = 1;
			return 32'h80000000;
		end
		return int'(v);
	endfunction

	function automatic int scaled_rhs(logic [31:0] div);
		longint sd;
		longint unsigned mag;
		longint unsigned prod;
		sd = longint'($signed(div));
		mag = (sd < 0) ? longint'(-sd) : longint'(sd);
		prod = (mag * longint'(sh_scale)) >> 16;
		return saturate(sd < 0 ? -longint'(prod) : longint'(prod));
	endfunction

	function automatic void relax_all(int nx, int ny, int nz);
		int at, cnt;
		longint acc, v;
		for (int c = 0; c < CELLS_MAX; c++) p_mem[c] = 0;
		for (int it = 0; it < sh_sweeps; it++)
			for (int par = 0; par < 2; par++)
				for (int k = 0; k < nz; k++)
					for (int j = 0; j < ny; j++)
						for (int i = 0; i < nx; i++) begin
							if (((i + j + k) & 1) != par) continue;
							at = (k * ny + j) * nx + i;
							acc = 0;
							cnt = 0;
							if (i > 0) begin acc += p_mem[at - 1]; cnt++; end
							if (i + 1 < nx) begin acc += p_mem[at + 1]; cnt++; end
							if (j > 0) begin acc += p_mem[at - nx]; cnt++; end
							if (j + 1 < ny) begin acc += p_mem[at + nx]; cnt++; end
							if (k > 0) begin acc += p_mem[at - nx * ny]; cnt++; end
							if (k + 1 < nz) begin acc += p_mem[at + nx * ny]; cnt++; end
							if (cnt == 0) begin
								p_mem[at] = 0;
								continue;
							end
							v = acc - longint'(rhs_mem[at]);
							// Signed division of longint truncates toward zero.
							p_mem[at] = saturate(v / cnt);
						end
	endfunction

	// Advances the shadow by one accepted item; returns 1 when a read result follows.
	function automatic bit solver_step(prbgs_pkg::action_t act, logic [prbgs_pkg::AW-1:0] idx,
			logic [31:0] div, bit last, output pressure_rd_t rd);
		int nx, ny, nz, cells;
		nx = axis(sh_gx, prbgs_pkg::MAX_GRID_X);
		ny = axis(sh_gy, prbgs_pkg::MAX_GRID_Y);
		nz = axis(sh_gz, prbgs_pkg::MAX_GRID_Z);
		cells = nx * ny * nz;
		if (act == prbgs_pkg::ACT_LOAD) begin
			if (!session_open) begin
				sat_flag = 0;
				session_open = 1;
			end
			if (idx < cells) rhs_mem[idx] = scaled_rhs(div);
			if (last) begin
				session_open = 0;
				relax_all(nx, ny, nz);
			end
			return 0;
		end
		rd.idx = idx;
		rd.pressure = (idx < cells) ? p_mem[idx] : 32'd0;
		rd.clip = sat_flag;
		return 1;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reads outstanding", $time, pending_reads.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rx_stall ? ($urandom_range(99) >= rx_stall_pct) : 1'b1;
		end
	end

	always @(posedge clk) begin
		pressure_rd_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read result idx=%0d p=%h c=%b", $time,
					read_index, pressure_value, clipped);
				errors++;
			end else begin
				w = pending_reads.pop_front();
				if (read_index !== w.idx) begin
					$display("%0t: read_index expected %0d got %0d", $time, w.idx, read_index);
					errors++;
				end
				if (pressure_value !== w.pressure) begin
					$display("%0t: pressure_value idx %0d expected %h got %h", $time, w.idx,
						w.pressure, pressure_value);
					errors++;
				end
				if (clipped !== w.clip) begin
					$display("%0t: clipped idx %0d expected %b got %b", $time, w.idx,
						w.clip, clipped);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(prbgs_pkg::cfg_idx_t sel, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		case (sel)
			prbgs_pkg::CFG_GRID_X: sh_gx = val[5:0];
			prbgs_pkg::CFG_GRID_Y: sh_gy = val[5:0];
			prbgs_pkg::CFG_GRID_Z: sh_gz = val[5:0];
			prbgs_pkg::CFG_SWEEP_COUNT: sh_sweeps = val[7:0];
			prbgs_pkg::CFG_RHS_SCALE: sh_scale = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Drives one item, waits for acceptance and queues what it should return.
	task automatic send_item(prbgs_pkg::action_t act, logic [prbgs_pkg::AW-1:0] idx,
			logic [31:0] div, bit last,
			bit typed = 0, logic [31:0] want_p = 0, logic want_c = 0);
		pressure_rd_t rd;
		@(negedge clk);
		while (tx_idle && $urandom_range(99) < tx_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		action = act;
		cell_index = idx;
		divergence_in = div;
		load_last = last;
		do @(posedge clk); while (!in_ready);
		if (solver_step(act, idx, div, last, rd)) begin
			if (typed) begin
				rd.pressure = want_p;
				rd.clip = want_c;
			end
			pending_reads.push_back(rd);
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic void add_item(prbgs_pkg::action_t act, int idx, logic [31:0] div,
			bit last, bit typed = 0, logic [31:0] want_p = 0, logic want_c = 0);
		dir_row_t r;
		r = '{0, prbgs_pkg::CFG_GRID_X, 0, act, idx, div, last, typed, want_p, want_c};
		dir_tab.push_back(r);
	endfunction

	function automatic void add_reg(prbgs_pkg::cfg_idx_t sel, logic [31:0] val);
		dir_row_t r;
		r = '{1, sel, val, prbgs_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0};
		dir_tab.push_back(r);
	endfunction

	// One load session over a small grid followed by a burst of reads.
	task automatic run_session(int n, bit long_hold);
		int nx, ny, nz, cells, order[$], pick;
		logic [31:0] sc;
		if (n == 5) begin
			write_reg(prbgs_pkg::CFG_GRID_X, 2);
			write_reg(prbgs_pkg::CFG_GRID_Y, 1);
			write_reg(prbgs_pkg::CFG_GRID_Z, 1);
			write_reg(prbgs_pkg::CFG_SWEEP_COUNT, 255);
		end else begin
			write_reg(prbgs_pkg::CFG_GRID_X,
				($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4));
			write_reg(prbgs_pkg::CFG_GRID_Y, $urandom_range(1, 3));
			write_reg(prbgs_pkg::CFG_GRID_Z, $urandom_range(1, 3));
			write_reg(prbgs_pkg::CFG_SWEEP_COUNT, $urandom_range(0, 6));
		end
		case ($urandom_range(4))
			0: sc = 32'h0001_0000;
			1: sc = $urandom_range(32'h4_0000);
			2: sc = 32'hffff_ffff;
			3: sc = 0;
			default: sc = $urandom;
		endcase
		write_reg(prbgs_pkg::CFG_RHS_SCALE, sc);
		nx = axis(sh_gx, prbgs_pkg::MAX_GRID_X);
		ny = axis(sh_gy, prbgs_pkg::MAX_GRID_Y);
		nz = axis(sh_gz, prbgs_pkg::MAX_GRID_Z);
		cells = nx * ny * nz;
		for (int c = 0; c < cells; c++) order.push_back(c);
		order.shuffle();
		// Every cell in the grid gets a right-hand side before the solve reads it.
		foreach (order[c]) begin
			if ($urandom_range(9) == 0)
				send_item(prbgs_pkg::ACT_LOAD, $urandom_range(cells, 32767), $urandom, 0);
			send_item(prbgs_pkg::ACT_LOAD, order[c], $urandom, 0);
		end
		pick = ($urandom_range(3) == 0) ? $urandom_range(cells, 32767) : $urandom_range(cells - 1);
		send_item(prbgs_pkg::ACT_LOAD, pick, $urandom, 1);
		if (long_hold) hold_req = 1;
		for (int r = 0; r < READS_PER_SESSION; r++) begin
			pick = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(cells - 1);
			send_item(prbgs_pkg::ACT_READ, pick, $urandom, $urandom_range(1));
		end
		drain();
	endtask

	initial begin
		sh_gx = 32;
		sh_gy = 32;
		sh_gz = 32;
		sh_sweeps = 20;
		sh_scale = 32'h0001_0000;
		sat_flag = 0;
		session_open = 0;
		for (int c = 0; c < CELLS_MAX; c++) begin
			rhs_mem[c] = 0;
			p_mem[c] = 0;
		end

		add_item(prbgs_pkg::ACT_READ, 5, 0, 0, 1, 0, 0);
		add_reg(prbgs_pkg::CFG_GRID_X, 0);
		add_reg(prbgs_pkg::CFG_GRID_Y, 1);
		add_reg(prbgs_pkg::CFG_GRID_Z, 1);
		add_reg(prbgs_pkg::CFG_SWEEP_COUNT, 1);
		add_item(prbgs_pkg::ACT_LOAD, 0, 32'h7fffffff, 0);
		add_item(prbgs_pkg::ACT_LOAD, 32767, 5, 1);
		// A lone cell has no neighbors and solves to zero.
		add_item(prbgs_pkg::ACT_READ, 0, 0, 0, 1, 0, 0);
		add_item(prbgs_pkg::ACT_READ, 32767, 32'hffffffff, 1, 1, 0, 0);
		add_reg(prbgs_pkg::CFG_RHS_SCALE, 32'hffffffff);
		add_reg(prbgs_pkg::CFG_GRID_X, 2);
		add_item(prbgs_pkg::ACT_LOAD, 0, 32'h7fffffff, 0);
		add_item(prbgs_pkg::ACT_LOAD, 1, 32'h80000000, 1);
		add_item(prbgs_pkg::ACT_READ, 0, 0, 0);
		add_item(prbgs_pkg::ACT_READ, 1, 0, 0);
		// Largest grid with no iterations only clears the pressure store.
		add_reg(prbgs_pkg::CFG_SWEEP_COUNT, 0);
		add_reg(prbgs_pkg::CFG_GRID_X, 63);
		add_reg(prbgs_pkg::CFG_GRID_Y, 40);
		add_reg(prbgs_pkg::CFG_GRID_Z, 32);
		add_item(prbgs_pkg::ACT_LOAD, 32767, 1234, 1);
		add_item(prbgs_pkg::ACT_READ, 32767, 0, 0, 1, 0, 0);
		add_item(prbgs_pkg::ACT_READ, 100, 0, 0, 1, 0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
			end else begin
				send_item(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].div, dir_tab[i].last,
					dir_tab[i].typed, dir_tab[i].want_p, dir_tab[i].want_c);
			end
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle = (ph == 1) || (ph == 3);
			rx_stall = (ph == 2) || (ph == 3);
			tx_idle_pct = (ph == 3) ? 21 : 87;
			rx_stall_pct = (ph == 3) ? 21 : 87;
			for (int s = 0; s < SESSIONS_PER_PHASE; s++)
				run_session(ph * SESSIONS_PER_PHASE + s, (ph == 0) && (s == 0));
		end

		drain();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
